@@ rtl/dlts_pkg.sv @@
// Shared constants, codes and types of the delta-list task scheduler.
package dlts_pkg;

    localparam int MAX_TASKS_DEF = 16;

    // Field widths of one transaction
    localparam int KIND_W   = 2;
    localparam int HANDLE_W = 8;
    localparam int TIME_W   = 32;
    localparam int POS_W    = 4;
    localparam int COUNT_W  = 5;

    // Width that holds any list index, length or position plus one (MAX_TASKS <= 64)
    localparam int EXT_W = 8;

    typedef logic [KIND_W-1:0] kind_t;
    localparam kind_t KIND_ADD      = 2'd0;
    localparam kind_t KIND_DELETE   = 2'd1;
    localparam kind_t KIND_TICK     = 2'd2;
    localparam kind_t KIND_DISPATCH = 2'd3;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [TIME_W-1:0]   delta;
        logic [TIME_W-1:0]   period;
    } entry_t;

    // Read address select
    typedef logic [2:0] rd_sel_t;
    localparam rd_sel_t RD_NONE     = 3'd0;
    localparam rd_sel_t RD_ZERO     = 3'd1;
    localparam rd_sel_t RD_POS      = 3'd2;
    localparam rd_sel_t RD_IDX_NEXT = 3'd3;
    localparam rd_sel_t RD_P        = 3'd4;

    // Insertion index operation
    typedef logic [1:0] idx_op_t;
    localparam idx_op_t IDX_HOLD = 2'd0;
    localparam idx_op_t IDX_CLR  = 2'd1;
    localparam idx_op_t IDX_STEP = 2'd2;

    // Shift pointer operation
    typedef logic [2:0] p_op_t;
    localparam p_op_t P_HOLD   = 3'd0;
    localparam p_op_t P_LEN_M1 = 3'd1;
    localparam p_op_t P_POS_P1 = 3'd2;
    localparam p_op_t P_DEC    = 3'd3;
    localparam p_op_t P_INC    = 3'd4;

    // Direct write select
    typedef logic [1:0] wr_sel_t;
    localparam wr_sel_t WR_NONE   = 2'd0;
    localparam wr_sel_t WR_FOLLOW = 2'd1;
    localparam wr_sel_t WR_NEW    = 2'd2;
    localparam wr_sel_t WR_TICK   = 2'd3;

    // Direction of an entry move
    localparam logic MV_UP   = 1'b0;
    localparam logic MV_DOWN = 1'b1;

    typedef struct packed {
        logic    capture;
        rd_sel_t rd_sel;
        idx_op_t idx_op;
        p_op_t   p_op;
        wr_sel_t wr_sel;
        logic    mv_rd;
        logic    mv_dir;
        logic    save_stop;
        logic    fold_arm;
        logic    load_head;
        logic    pos_zero;
        logic    len_inc;
        logic    len_dec;
        logic    ready_set;
        logic    ready_clr;
        logic    set_acc;
        logic    set_run;
        logic    load_result;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  add_refuse;
        logic  pos_bad;
        logic  list_empty;
        logic  head_ready;
        logic  walk_go;
        logic  idx_at_len;
        logic  idx_last;
        logic  p_stop_up;
        logic  has_succ;
        logic  p_stop_down;
        logic  head_zero;
    } status_t;

endpackage

@@ rtl/dlts_in_if.sv @@
// Request channel of the scheduler: one operation per transaction.
interface dlts_in_if;
    import dlts_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [HANDLE_W-1:0] task_handle;
    logic [TIME_W-1:0]   first_delay;
    logic [TIME_W-1:0]   repeat_period;
    logic [POS_W-1:0]    position;

    modport source (
        output valid, kind, task_handle, first_delay, repeat_period, position,
        input  ready
    );
    modport sink (
        input  valid, kind, task_handle, first_delay, repeat_period, position,
        output ready
    );
endinterface

@@ rtl/dlts_out_if.sv @@
// Result channel of the scheduler: one result per request transaction.
interface dlts_out_if;
    import dlts_pkg::*;

    logic                valid;
    logic                ready;
    logic                accepted;
    logic                run_valid;
    logic [HANDLE_W-1:0] run_handle;
    logic [COUNT_W-1:0]  entry_count;

    modport source (
        output valid, accepted, run_valid, run_handle, entry_count,
        input  ready
    );
    modport sink (
        input  valid, accepted, run_valid, run_handle, entry_count,
        output ready
    );
endinterface

@@ rtl/delta_list_task_scheduler_core.sv @@
// Top level of the delta-list periodic task scheduler.
// A tick touches only the head; a delete shifts the entries after the position, an add walks
// and shifts the list, and a dispatch removes the head and adds it back one period on.
// One transaction is worked on at a time, on the single entry memory, which moves one entry
// per cycle through one read and one write port.
// Reset (rst_n low, asynchronous) empties the list and clears the head-ready flag;
// the entry memory keeps its contents and needs no clearing pass.
module delta_list_task_scheduler_core #(
    parameter int MAX_TASKS = dlts_pkg::MAX_TASKS_DEF
) (
    input logic       clk,
    input logic       rst_n,
    dlts_in_if.sink   request,
    dlts_out_if.source result
);
    import dlts_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Controller: owns the handshakes and the sequence of each operation
    dlts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_ready  (request.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath: holds the delta-sorted list and the result register, so a finished
    // result can wait on the output while the next transaction is taken in
    dlts_dpath #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .kind          (request.kind),
        .task_handle   (request.task_handle),
        .first_delay   (request.first_delay),
        .repeat_period (request.repeat_period),
        .position      (request.position),
        .accepted      (result.accepted),
        .run_valid     (result.run_valid),
        .run_handle    (result.run_handle),
        .entry_count   (result.entry_count)
    );

endmodule

@@ rtl/dlts_dpath.sv @@
// Datapath of the scheduler: entry memory, list registers, walk and shift arithmetic.
module dlts_dpath #(
    parameter int MAX_TASKS = dlts_pkg::MAX_TASKS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dlts_pkg::cmd_t                cmd,
    output dlts_pkg::status_t             status,
    input  logic [dlts_pkg::KIND_W-1:0]   kind,
    input  logic [dlts_pkg::HANDLE_W-1:0] task_handle,
    input  logic [dlts_pkg::TIME_W-1:0]   first_delay,
    input  logic [dlts_pkg::TIME_W-1:0]   repeat_period,
    input  logic [dlts_pkg::POS_W-1:0]    position,
    output logic                          accepted,
    output logic                          run_valid,
    output logic [dlts_pkg::HANDLE_W-1:0] run_handle,
    output logic [dlts_pkg::COUNT_W-1:0]  entry_count
);
    import dlts_pkg::*;

    localparam int AW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);

    // Entry memory: one write and one registered read per cycle
    entry_t mem [MAX_TASKS];

    // Captured operation
    kind_t               op_kind_reg;
    logic [HANDLE_W-1:0] op_handle_reg;
    logic [TIME_W-1:0]   op_delay_reg;
    logic [TIME_W-1:0]   op_period_reg;
    logic [POS_W-1:0]    op_pos_reg;

    // List and walk state
    logic [CW-1:0] len_reg, len_next;
    logic          ready_reg, ready_next;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] p_reg;
    logic [AW-1:0] rd_addr_reg;
    entry_t        rd_data_reg;
    entry_t        stop_reg;
    logic          mv_pend_reg, mv_pend_next;
    logic          mv_dir_reg;
    logic          fold_reg, fold_next;
    logic          res_acc_reg, res_acc_next;
    logic          res_run_reg, res_run_next;

    // Result registers
    logic                acc_out_reg;
    logic                run_out_reg;
    logic [HANDLE_W-1:0] handle_out_reg;
    logic [COUNT_W-1:0]  count_out_reg;

    logic [EXT_W-1:0] len_ext;
    logic [EXT_W-1:0] pos_ext;
    logic [EXT_W-1:0] idx_ext;
    logic [EXT_W-1:0] p_ext;
    logic [EXT_W-1:0] idx_p1;
    logic [EXT_W-1:0] pos_p1;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;

    assign len_ext = EXT_W'(len_reg);
    assign pos_ext = EXT_W'(op_pos_reg);
    assign idx_ext = EXT_W'(idx_reg);
    assign p_ext   = EXT_W'(p_reg);
    assign idx_p1  = idx_ext + EXT_W'(1);
    assign pos_p1  = pos_ext + EXT_W'(1);

    always_comb
    begin
        status.kind        = op_kind_reg;
        status.add_refuse  = (len_reg == CW'(MAX_TASKS)) || (op_period_reg == '0);
        status.pos_bad     = pos_ext >= len_ext;
        status.list_empty  = (len_reg == '0);
        status.head_ready  = ready_reg;
        status.walk_go     = (idx_reg < len_reg) && (op_delay_reg >= rd_data_reg.delta);
        status.idx_at_len  = (idx_reg == len_reg);
        status.idx_last    = (idx_p1 == len_ext);
        status.p_stop_up   = (p_ext == idx_p1);
        status.has_succ    = (pos_p1 < len_ext);
        status.p_stop_down = ((p_ext + EXT_W'(1)) == len_ext);
        status.head_zero   = (rd_data_reg.delta == '0);
    end

    // Read address
    always_comb
    begin
        case (cmd.rd_sel)
            RD_ZERO:     rd_addr = '0;
            RD_POS:      rd_addr = pos_ext[AW-1:0];
            RD_IDX_NEXT: rd_addr = idx_p1[AW-1:0];
            RD_P:        rd_addr = p_reg[AW-1:0];
            default:     rd_addr = '0;
        endcase
        rd_en = (cmd.rd_sel != RD_NONE);
    end

    // Write port: a pending move takes precedence, the controller keeps them apart
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = rd_data_reg;
        if (mv_pend_reg)
        begin
            wr_en = 1'b1;
            if (mv_dir_reg == MV_DOWN)
            begin
                wr_addr = rd_addr_reg - AW'(1);
                if (fold_reg)
                begin
                    wr_data.delta = rd_data_reg.delta + stop_reg.delta;
                end
            end
            else
            begin
                wr_addr = rd_addr_reg + AW'(1);
            end
        end
        else
        begin
            case (cmd.wr_sel)
                WR_FOLLOW:
                begin
                    wr_en         = 1'b1;
                    wr_addr       = idx_p1[AW-1:0];
                    wr_data       = stop_reg;
                    wr_data.delta = stop_reg.delta - op_delay_reg;
                end
                WR_NEW:
                begin
                    wr_en          = 1'b1;
                    wr_addr        = idx_reg[AW-1:0];
                    wr_data.handle = op_handle_reg;
                    wr_data.delta  = op_delay_reg;
                    wr_data.period = op_period_reg;
                end
                WR_TICK:
                begin
                    wr_en         = 1'b1;
                    wr_addr       = '0;
                    wr_data.delta = rd_data_reg.delta - TIME_W'(1);
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    // Control state next values
    always_comb
    begin
        len_next     = len_reg;
        ready_next   = ready_reg;
        mv_pend_next = cmd.mv_rd;
        fold_next    = fold_reg;
        res_acc_next = res_acc_reg;
        res_run_next = res_run_reg;

        if (cmd.len_inc)
        begin
            len_next = len_reg + CW'(1);
        end
        else if (cmd.len_dec)
        begin
            len_next = len_reg - CW'(1);
        end

        if (cmd.ready_set)
        begin
            ready_next = 1'b1;
        end
        else if (cmd.ready_clr && (op_pos_reg == '0))
        begin
            ready_next = 1'b0;
        end

        if (cmd.fold_arm)
        begin
            fold_next = 1'b1;
        end
        else if (mv_pend_reg)
        begin
            fold_next = 1'b0;
        end

        if (cmd.capture)
        begin
            res_acc_next = 1'b0;
            res_run_next = 1'b0;
        end
        else
        begin
            if (cmd.set_acc)
            begin
                res_acc_next = 1'b1;
            end
            if (cmd.set_run)
            begin
                res_run_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg     <= '0;
            ready_reg   <= 1'b0;
            mv_pend_reg <= 1'b0;
            fold_reg    <= 1'b0;
            res_acc_reg <= 1'b0;
            res_run_reg <= 1'b0;
        end
        else
        begin
            len_reg     <= len_next;
            ready_reg   <= ready_next;
            mv_pend_reg <= mv_pend_next;
            fold_reg    <= fold_next;
            res_acc_reg <= res_acc_next;
            res_run_reg <= res_run_next;
        end
    end

    // Operation, index and pointer registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_kind_reg   <= kind;
            op_handle_reg <= task_handle;
            op_delay_reg  <= first_delay;
            op_period_reg <= repeat_period;
            op_pos_reg    <= position;
        end
        else if (cmd.load_head)
        begin
            op_handle_reg <= rd_data_reg.handle;
            op_delay_reg  <= rd_data_reg.period;
            op_period_reg <= rd_data_reg.period;
        end
        else if (cmd.idx_op == IDX_STEP)
        begin
            op_delay_reg <= op_delay_reg - rd_data_reg.delta;
        end

        if (cmd.pos_zero)
        begin
            op_pos_reg <= '0;
        end

        case (cmd.idx_op)
            IDX_CLR:  idx_reg <= '0;
            IDX_STEP: idx_reg <= idx_reg + CW'(1);
            default:  idx_reg <= idx_reg;
        endcase

        case (cmd.p_op)
            P_LEN_M1: p_reg <= len_reg - CW'(1);
            P_POS_P1: p_reg <= pos_p1[CW-1:0];
            P_DEC:    p_reg <= p_reg - CW'(1);
            P_INC:    p_reg <= p_reg + CW'(1);
            default:  p_reg <= p_reg;
        endcase

        if (cmd.mv_rd)
        begin
            mv_dir_reg <= cmd.mv_dir;
        end

        if (cmd.save_stop)
        begin
            stop_reg <= rd_data_reg;
        end

        if (cmd.load_result)
        begin
            acc_out_reg    <= res_acc_reg;
            run_out_reg    <= res_run_reg;
            handle_out_reg <= res_run_reg ? op_handle_reg : '0;
            count_out_reg  <= len_ext[COUNT_W-1:0];
        end
    end

    assign accepted    = acc_out_reg;
    assign run_valid   = run_out_reg;
    assign run_handle  = handle_out_reg;
    assign entry_count = count_out_reg;

    a_len_bound : assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= CW'(MAX_TASKS))
        else $error("list length beyond capacity");

    a_ready_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg |-> (len_reg != '0))
        else $error("head marked ready on an empty list");

    a_port_conflict : assert property (@(posedge clk) disable iff (!rst_n)
        mv_pend_reg |-> (cmd.wr_sel == WR_NONE))
        else $error("entry move collides with a direct write");

    a_len_step : assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.len_inc && cmd.len_dec))
        else $error("length raised and lowered together");

endmodule

@@ rtl/dlts_ctrl.sv @@
// Controller of the scheduler: sequences walks, shifts and head updates.
module dlts_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  dlts_pkg::status_t status,
    output dlts_pkg::cmd_t    cmd
);
    import dlts_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_I_START  = 4'd2;
    localparam logic [3:0] S_I_WALK   = 4'd3;
    localparam logic [3:0] S_I_SHIFT  = 4'd4;
    localparam logic [3:0] S_I_DRAIN  = 4'd5;
    localparam logic [3:0] S_I_FOLLOW = 4'd6;
    localparam logic [3:0] S_I_NEW    = 4'd7;
    localparam logic [3:0] S_R_START  = 4'd8;
    localparam logic [3:0] S_R_HEAD   = 4'd9;
    localparam logic [3:0] S_R_SHIFT  = 4'd10;
    localparam logic [3:0] S_R_DRAIN  = 4'd11;
    localparam logic [3:0] S_R_END    = 4'd12;
    localparam logic [3:0] S_T_START  = 4'd13;
    localparam logic [3:0] S_T_CHECK  = 4'd14;
    localparam logic [3:0] S_DONE     = 4'd15;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       in_fire;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        cmd.capture    = in_fire;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (status.kind)
                    KIND_ADD:
                        state_next = status.add_refuse ? S_DONE : S_I_START;
                    KIND_DELETE:
                        state_next = status.pos_bad ? S_DONE : S_R_START;
                    KIND_TICK:
                        state_next = (status.list_empty || status.head_ready) ?
                                     S_DONE : S_T_START;
                    default:
                    begin
                        if (!status.head_ready || status.list_empty)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cmd.pos_zero = 1'b1;
                            cmd.set_run  = 1'b1;
                            state_next   = S_R_START;
                        end
                    end
                endcase
            end
            // Insert: walk the deltas from the head
            S_I_START:
            begin
                cmd.rd_sel = RD_ZERO;
                cmd.idx_op = IDX_CLR;
                state_next = S_I_WALK;
            end
            S_I_WALK:
            begin
                if (status.walk_go)
                begin
                    cmd.idx_op = IDX_STEP;
                    cmd.rd_sel = RD_IDX_NEXT;
                end
                else
                begin
                    cmd.save_stop = 1'b1;
                    if (status.idx_at_len)
                    begin
                        state_next = S_I_NEW;
                    end
                    else if (status.idx_last)
                    begin
                        state_next = S_I_FOLLOW;
                    end
                    else
                    begin
                        cmd.p_op   = P_LEN_M1;
                        state_next = S_I_SHIFT;
                    end
                end
            end
            S_I_SHIFT:
            begin
                cmd.rd_sel = RD_P;
                cmd.mv_rd  = 1'b1;
                cmd.mv_dir = MV_UP;
                if (status.p_stop_up)
                begin
                    state_next = S_I_DRAIN;
                end
                else
                begin
                    cmd.p_op = P_DEC;
                end
            end
            S_I_DRAIN:
            begin
                state_next = S_I_FOLLOW;
            end
            S_I_FOLLOW:
            begin
                cmd.wr_sel = WR_FOLLOW;
                state_next = S_I_NEW;
            end
            S_I_NEW:
            begin
                cmd.wr_sel  = WR_NEW;
                cmd.len_inc = 1'b1;
                cmd.set_acc = (status.kind == KIND_ADD);
                state_next  = S_DONE;
            end
            // Remove: fold the delta into the successor, close the gap
            S_R_START:
            begin
                cmd.rd_sel = RD_POS;
                state_next = S_R_HEAD;
            end
            S_R_HEAD:
            begin
                cmd.save_stop = 1'b1;
                cmd.fold_arm  = 1'b1;
                cmd.load_head = (status.kind == KIND_DISPATCH);
                if (status.has_succ)
                begin
                    cmd.p_op   = P_POS_P1;
                    state_next = S_R_SHIFT;
                end
                else
                begin
                    state_next = S_R_END;
                end
            end
            S_R_SHIFT:
            begin
                cmd.rd_sel = RD_P;
                cmd.mv_rd  = 1'b1;
                cmd.mv_dir = MV_DOWN;
                if (status.p_stop_down)
                begin
                    state_next = S_R_DRAIN;
                end
                else
                begin
                    cmd.p_op = P_INC;
                end
            end
            S_R_DRAIN:
            begin
                state_next = S_R_END;
            end
            S_R_END:
            begin
                cmd.len_dec   = 1'b1;
                cmd.ready_clr = 1'b1;
                if (status.kind == KIND_DISPATCH)
                begin
                    state_next = S_I_START;
                end
                else
                begin
                    cmd.set_acc = 1'b1;
                    state_next  = S_DONE;
                end
            end
            // Tick: count down the head only, or mark it ready once its delta is zero
            S_T_START:
            begin
                cmd.rd_sel = RD_ZERO;
                state_next = S_T_CHECK;
            end
            S_T_CHECK:
            begin
                if (status.head_zero)
                begin
                    cmd.ready_set = 1'b1;
                end
                else
                begin
                    cmd.wr_sel = WR_TICK;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_result = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_fire_decode : assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == S_DECODE))
        else $error("accepted transaction not decoded");

    a_new_done : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_I_NEW) |=> (state_reg == S_DONE))
        else $error("insert did not finish after the new entry");

endmodule

@@ tb/sv/tb_delta_list_task_scheduler_core.sv @@
// Self-checking testbench for the delta-list task scheduler core.
`timescale 1ns / 1ps

module tb_delta_list_task_scheduler_core;
    import dlts_pkg::*;

    localparam int TASK_SLOTS  = MAX_TASKS_DEF;
    // Long enough to cover the receiver hold-off and the slowest dispatch many times over
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    // Margin after the last result, longer than the longest transaction (dispatch on a full list)
    localparam int DRAIN_CYCLES = 80;

    // One request transaction as the sender presents it
    typedef struct packed {
        kind_t               kind;
        logic [HANDLE_W-1:0] handle;
        logic [TIME_W-1:0]   delay;
        logic [TIME_W-1:0]   period;
        logic [POS_W-1:0]    pos;
    } sched_op_t;

    // One result transaction
    typedef struct packed {
        logic                accepted;
        logic                run_valid;
        logic [HANDLE_W-1:0] run_handle;
        logic [COUNT_W-1:0]  entry_count;
    } sched_result_t;

    logic clk;
    logic rst_n;

    dlts_in_if  req_if ();
    dlts_out_if res_if ();

    delta_list_task_scheduler_core #(
        .MAX_TASKS (TASK_SLOTS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_if.sink),
        .result  (res_if.source)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the delta list, advanced once per accepted request
    // ------------------------------------------------------------------
    logic [HANDLE_W-1:0] shadow_handle [TASK_SLOTS];
    logic [TIME_W-1:0]   shadow_delta  [TASK_SLOTS];
    logic [TIME_W-1:0]   shadow_period [TASK_SLOTS];
    logic                head_due   = 1'b0;
    int unsigned         list_len   = 0;

    sched_op_t     op_backlog [$];   // requests still to be offered
    sched_result_t op_outcomes [$];  // predicted results, oldest first

    int  fail_count     = 0;
    int  send_idle_pct  = 0;
    int  recv_idle_pct  = 0;
    bit  start_hold     = 1'b0;
    bit  hold_done      = 1'b0;
    int  hold_left      = 0;
    bit  req_taken      = 1'b0;

    // Walk the list subtracting deltas; equal due times place the new task last
    function automatic bit list_insert(logic [HANDLE_W-1:0] h, logic [TIME_W-1:0] d,
                                       logic [TIME_W-1:0] p);
        int unsigned idx;
        if (list_len >= TASK_SLOTS || p == '0)
            return 1'b0;
        idx = 0;
        while (idx < list_len && d >= shadow_delta[idx]) begin
            d   = d - shadow_delta[idx];
            idx = idx + 1;
        end
        for (int unsigned k = list_len; k > idx; k--) begin
            shadow_handle[k] = shadow_handle[k-1];
            shadow_delta[k]  = shadow_delta[k-1];
            shadow_period[k] = shadow_period[k-1];
        end
        shadow_handle[idx] = h;
        shadow_delta[idx]  = d;
        shadow_period[idx] = p;
        if (idx < list_len)
            shadow_delta[idx+1] = shadow_delta[idx+1] - d;
        list_len = list_len + 1;
        return 1'b1;
    endfunction

    // Fold the removed delta into the successor so later tasks keep their due times
    function automatic bit list_remove(int unsigned at);
        if (at >= list_len)
            return 1'b0;
        if (at + 1 < list_len)
            shadow_delta[at+1] = shadow_delta[at+1] + shadow_delta[at];
        for (int unsigned k = at; k + 1 < list_len; k++) begin
            shadow_handle[k] = shadow_handle[k+1];
            shadow_delta[k]  = shadow_delta[k+1];
            shadow_period[k] = shadow_period[k+1];
        end
        list_len = list_len - 1;
        if (at == 0)
            head_due = 1'b0;
        return 1'b1;
    endfunction

    function automatic sched_result_t apply_to_list(sched_op_t op);
        sched_result_t       r;
        logic [HANDLE_W-1:0] h;
        logic [TIME_W-1:0]   p;
        r = '0;
        case (op.kind)
            KIND_ADD:
                r.accepted = list_insert(op.handle, op.delay, op.period);
            KIND_DELETE:
                r.accepted = list_remove(int'(op.pos));
            KIND_TICK:
                // Only the head counts down; a ready head waits for its dispatch
                if (list_len > 0 && !head_due) begin
                    if (shadow_delta[0] == '0)
                        head_due = 1'b1;
                    else
                        shadow_delta[0] = shadow_delta[0] - 1'b1;
                end
            default:
                // Pop the ready head and re-arm it one period on
                if (head_due && list_len > 0) begin
                    h            = shadow_handle[0];
                    p            = shadow_period[0];
                    r.run_valid  = 1'b1;
                    r.run_handle = h;
                    void'(list_remove(0));
                    void'(list_insert(h, p, p));
                end
        endcase
        r.entry_count = COUNT_W'(list_len);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_op(kind_t k, logic [HANDLE_W-1:0] h, logic [TIME_W-1:0] d,
                           logic [TIME_W-1:0] p, logic [POS_W-1:0] at);
        sched_op_t op;
        op.kind   = k;
        op.handle = h;
        op.delay  = d;
        op.period = p;
        op.pos    = at;
        op_backlog.push_back(op);
    endtask

    // Mostly short delays so that heads fall due; now and then the full range
    function automatic logic [TIME_W-1:0] rand_delay();
        int unsigned pick;
        pick = $urandom_range(0, 15);
        if (pick == 0)
            return $urandom;
        if (pick == 1)
            return '1;
        return TIME_W'($urandom_range(0, 6));
    endfunction

    function automatic logic [TIME_W-1:0] rand_period();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return $urandom;
        if (pick == 2)
            return '1;
        return TIME_W'($urandom_range(1, 8));
    endfunction

    // Queue bursts of well-formed activity with random content, plus a little noise
    task automatic queue_random_phase(int n);
        int          queued;
        int unsigned pick;
        int unsigned len;
        queued = 0;
        while (queued < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 22) begin
                // fill burst: long enough to reach a full list and see refusals
                len = $urandom_range(6, 18);
                repeat (len)
                    push_op(KIND_ADD, HANDLE_W'($urandom), rand_delay(), rand_period(),
                            POS_W'($urandom));
            end else if (pick < 67) begin
                // run burst: ticks advance the head, dispatches pop and re-arm it
                len = $urandom_range(10, 40);
                repeat (len)
                    push_op(($urandom_range(0, 9) < 6) ? KIND_TICK : KIND_DISPATCH,
                            HANDLE_W'($urandom), $urandom, $urandom, POS_W'($urandom));
            end else if (pick < 90) begin
                // prune burst: favour the head so stuck long delays get cleared
                len = $urandom_range(2, 10);
                repeat (len)
                    push_op(KIND_DELETE, HANDLE_W'($urandom), $urandom, $urandom,
                            ($urandom_range(0, 2) == 0) ? '0 : POS_W'($urandom));
            end else begin
                len = $urandom_range(1, 4);
                repeat (len)
                    push_op(kind_t'($urandom), HANDLE_W'($urandom), $urandom, $urandom,
                            POS_W'($urandom));
            end
            queued = queued + int'(len);
        end
    endtask

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        // Hold every input at a known value before the first edge
        rst_n                = 1'b0;
        req_if.valid         = 1'b0;
        req_if.kind          = KIND_TICK;
        req_if.task_handle   = '0;
        req_if.first_delay   = '0;
        req_if.repeat_period = '0;
        req_if.position      = '0;
        res_if.ready         = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Driver: offer the oldest pending request at the falling edge, hold it
    // until the block takes it, and idle between requests at random
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        logic      next_valid;
        sched_op_t next_op;
        if (rst_n) begin
            if (req_taken)
                op_backlog.delete(0);
            next_valid = 1'b0;
            if (req_if.valid && !req_taken) begin
                // hold the current request, it has not been taken yet
                next_valid = 1'b1;
            end else if (op_backlog.size() != 0 &&
                         $urandom_range(0, 99) >= send_idle_pct) begin
                next_op               = op_backlog[0];
                next_valid            = 1'b1;
                req_if.kind          <= next_op.kind;
                req_if.task_handle   <= next_op.handle;
                req_if.first_delay   <= next_op.delay;
                req_if.repeat_period <= next_op.period;
                req_if.position      <= next_op.pos;
            end
            req_if.valid <= next_valid;
        end
    end

    // Receiver: random back-pressure, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (start_hold && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left     = hold_left - 1;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on each accepted request, check each accepted result
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        sched_op_t     op;
        sched_result_t got;
        sched_result_t want;
        req_taken <= rst_n && req_if.valid && req_if.ready;
        if (rst_n && req_if.valid && req_if.ready) begin
            op.kind   = req_if.kind;
            op.handle = req_if.task_handle;
            op.delay  = req_if.first_delay;
            op.period = req_if.repeat_period;
            op.pos    = req_if.position;
            op_outcomes.push_back(apply_to_list(op));
        end
        if (rst_n && res_if.valid && res_if.ready) begin
            got.accepted    = res_if.accepted;
            got.run_valid   = res_if.run_valid;
            got.run_handle  = res_if.run_handle;
            got.entry_count = res_if.entry_count;
            if (op_outcomes.size() == 0) begin
                fail_count = fail_count + 1;
                $display("%0t: result with none outstanding: acc=%0b run=%0b h=%0h cnt=%0d",
                         $time, got.accepted, got.run_valid, got.run_handle,
                         got.entry_count);
            end else begin
                want = op_outcomes.pop_front();
                if (got.accepted !== want.accepted || got.run_valid !== want.run_valid ||
                    got.run_handle !== want.run_handle ||
                    got.entry_count !== want.entry_count) begin
                    fail_count = fail_count + 1;
                    $display("%0t: mismatch: expected acc=%0b run=%0b h=%0h cnt=%0d, got acc=%0b run=%0b h=%0h cnt=%0d",
                             $time, want.accepted, want.run_valid, want.run_handle,
                             want.entry_count, got.accepted, got.run_valid,
                             got.run_handle, got.entry_count);
                end
            end
        end
    end

    // Watchdog: give up once nothing has moved on either channel for too long
    initial
    begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
                stall_cycles = 0;
            else
                stall_cycles = stall_cycles + 1;
        end
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence: directed opening, then three random phases with different idling
    // ------------------------------------------------------------------
    initial
    begin
        send_idle_pct = 11;
        recv_idle_pct = 71;

        // empty list: tick, dispatch and delete all leave it untouched
        push_op(KIND_TICK,     8'h00, '0, '0, 4'd0);
        push_op(KIND_DISPATCH, 8'h00, '0, '0, 4'd0);
        push_op(KIND_DELETE,   8'h00, '0, '0, 4'd0);
        // zero period is refused
        push_op(KIND_ADD,      8'hFF, '0, '0, 4'd0);
        push_op(KIND_ADD,      8'hFF, '0, 32'd1, 4'd0);
        // dispatch before the head is ready does nothing
        push_op(KIND_DISPATCH, 8'h00, '0, '0, 4'd0);
        push_op(KIND_TICK,     8'h00, '0, '0, 4'd0);
        // tick on a ready head does nothing
        push_op(KIND_TICK,     8'h00, '0, '0, 4'd0);
        push_op(KIND_DISPATCH, 8'h00, '0, '0, 4'd0);
        // widest delay and period go to the back
        push_op(KIND_ADD,      8'h00, '1, '1, 4'd0);
        // equal due time: lands after the re-armed task
        push_op(KIND_ADD,      8'h5A, 32'd1, 32'd3, 4'd0);
        // delete beyond the list, then the last entry
        push_op(KIND_DELETE,   8'h00, '0, '0, 4'd15);
        push_op(KIND_DELETE,   8'h00, '0, '0, 4'd2);
        push_op(KIND_TICK,     8'h00, '0, '0, 4'd0);
        push_op(KIND_TICK,     8'h00, '0, '0, 4'd0);
        // delete a ready head: ready flag drops, delta folds into the successor
        push_op(KIND_DELETE,   8'h00, '0, '0, 4'd0);
        push_op(KIND_ADD,      8'hA5, 32'h8000_0000, 32'h7FFF_FFFF, 4'd0);
        push_op(KIND_ADD,      8'h3C, 32'd2, 32'd1, 4'd0);
        // delete in the middle with a successor
        push_op(KIND_DELETE,   8'h00, '0, '0, 4'd1);
        push_op(KIND_TICK,     8'h00, '0, '0, 4'd0);
        push_op(KIND_DISPATCH, 8'h00, '0, '0, 4'd0);
        push_op(KIND_DELETE,   8'h00, '0, '0, 4'd0);
        push_op(KIND_DELETE,   8'h00, '0, '0, 4'd0);
        push_op(KIND_DELETE,   8'h00, '0, '0, 4'd0);

        queue_random_phase(410);
        while (op_backlog.size() != 0)
            @(posedge clk);

        // swap the idling: the sender is now the slow side
        send_idle_pct = 71;
        recv_idle_pct = 11;
        queue_random_phase(410);
        while (op_backlog.size() != 0)
            @(posedge clk);

        // no idling; open with a long receiver hold-off so the block backs up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        start_hold    = 1'b1;
        queue_random_phase(410);
        while (op_backlog.size() != 0 || op_outcomes.size() != 0)
            @(posedge clk);

        // let any stray result show itself before judging
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
